// ----- hw/rtl/lfps_pkg.sv -----
// ---------------------------------------------------------------------------
// lfps_pkg: shared types and constants for the line-follower PID steering
// Fixed field widths, register codes, reset values and the drive-to-duty map.
// ---------------------------------------------------------------------------
package lfps_pkg;

    // Fixed widths
    localparam int GAIN_W  = 20;
    localparam int INTEG_W = 21;
    localparam int CORR_W  = 10;
    localparam int DUTY_W  = 8;
    localparam int BASE_W  = 8;
    localparam int DRIVE_W = 12;
    localparam int CFG_DATA_W = 20;

    // Saturation limits
    localparam logic signed [INTEG_W-1:0] INTEG_HI = {1'b0, {(INTEG_W-1){1'b1}}};
    localparam logic signed [INTEG_W-1:0] INTEG_LO = {1'b1, {(INTEG_W-1){1'b0}}};
    localparam logic [CORR_W-1:0] CORR_LIMIT = 10'd1023;
    localparam logic [DUTY_W-1:0] DUTY_MAX   = 8'd255;

    // Register reset values
    localparam logic [BASE_W-1:0] BASE_SPEED_RST = 8'd90;
    localparam logic [GAIN_W-1:0] GAIN_PROP_RST  = 20'd8723;
    localparam logic [GAIN_W-1:0] GAIN_INTEG_RST = 20'd66;
    localparam logic [GAIN_W-1:0] GAIN_DERIV_RST = 20'd11796;

    // Register indexes
    typedef enum logic [1:0] {
        CFG_BASE_SPEED = 2'd0,
        CFG_GAIN_PROP  = 2'd1,
        CFG_GAIN_INTEG = 2'd2,
        CFG_GAIN_DERIV = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic              neg;
    } t_duty;

    // Map a signed drive to a duty magnitude and a negative flag
    function automatic t_duty drive_to_duty(input logic signed [DRIVE_W-1:0] drive);
        logic [DRIVE_W-1:0] mag;
        t_duty              res;
        mag = drive[DRIVE_W-1] ? DRIVE_W'(-drive) : DRIVE_W'(drive);
        res.neg  = drive[DRIVE_W-1];
        res.duty = (mag > DRIVE_W'(DUTY_MAX)) ? DUTY_MAX : mag[DUTY_W-1:0];
        return res;
    endfunction

endpackage

// ----- hw/rtl/lfps_intf.sv -----
// ---------------------------------------------------------------------------
// lfps_intf: channel interfaces of the line-follower PID steering
// Sensor word in, duty word out, and the register write channel.
// ---------------------------------------------------------------------------
interface lfps_in_if #(parameter int SENSOR_BITS = 10);
    logic                   valid;
    logic                   ready;
    logic [SENSOR_BITS-1:0] sensor_left;
    logic [SENSOR_BITS-1:0] sensor_right;

    modport source (output valid, output sensor_left, output sensor_right, input ready);
    modport sink   (input valid, input sensor_left, input sensor_right, output ready);
endinterface

interface lfps_out_if;
    logic                      valid;
    logic                      ready;
    logic [lfps_pkg::DUTY_W-1:0] duty_left;
    logic [lfps_pkg::DUTY_W-1:0] duty_right;
    logic                      spin_right;
    logic                      spin_left;

    modport source (output valid, output duty_left, output duty_right,
                    output spin_right, output spin_left, input ready);
    modport sink   (input valid, input duty_left, input duty_right,
                    input spin_right, input spin_left, output ready);
endinterface

interface lfps_cfg_if;
    logic                          valid;
    logic                          ready;
    lfps_pkg::t_cfg_idx            index;
    logic [lfps_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/line_follower_pid_steering.sv -----
// Throughput: one sensor word per cycle while the result channel is not
// stalled; four registered stages (error and integral, three gain
// multipliers, weighted sum, correction and drives).
// Each stage advances when the one after it is empty or moving on.
// Reset: valids, error history and integral clear; registers take defaults.
// ---------------------------------------------------------------------------
// line_follower_pid_steering: PID steering for a differential drive
// Forms left-minus-right error, a saturating integral and a difference,
// weights them by Q4.16 gains and splits the correction over two motors.
// ---------------------------------------------------------------------------
module line_follower_pid_steering #(
    parameter int SENSOR_BITS    = 10,
    parameter int GAIN_FRAC_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lfps_in_if.sink   i_in,
    lfps_out_if.source o_out,
    lfps_cfg_if.sink  i_cfg
);
    import lfps_pkg::*;

    localparam int ERR_W   = SENSOR_BITS + 1;
    localparam int DIFF_W  = SENSOR_BITS + 2;
    localparam int ACC_W   = ((ERR_W > INTEG_W) ? ERR_W : INTEG_W) + 1;
    localparam int SGAIN_W = GAIN_W + 1;
    localparam int PP_W    = SGAIN_W + ERR_W;
    localparam int PD_W    = SGAIN_W + DIFF_W;
    localparam int PI_W    = SGAIN_W + INTEG_W;
    localparam int PMAX_W  = (PI_W > PD_W) ? PI_W : PD_W;
    localparam int SUM_W   = PMAX_W + 2;

    // Configuration registers
    logic [BASE_W-1:0] r_base_speed;
    logic [GAIN_W-1:0] r_gain_prop;
    logic [GAIN_W-1:0] r_gain_integ;
    logic [GAIN_W-1:0] r_gain_deriv;

    // Stage valids and enables
    logic r_va, r_vb, r_vc, r_vd;
    logic en_a, en_b, en_c, en_d;
    logic accept;

    // Controller state
    logic signed [ERR_W-1:0]   r_last_err;
    logic signed [INTEG_W-1:0] r_integ_sum;

    // Stage payloads
    logic signed [ERR_W-1:0]   r_a_err;
    logic signed [DIFF_W-1:0]  r_a_diff;
    logic signed [INTEG_W-1:0] r_a_integ;
    logic signed [PP_W-1:0]    r_b_pp;
    logic signed [PD_W-1:0]    r_b_pd;
    logic signed [PI_W-1:0]    r_b_pi;
    logic signed [SUM_W-1:0]   r_c_sum;
    t_duty                     r_d_left;
    t_duty                     r_d_right;

    logic signed [ERR_W-1:0]   n_err;
    logic signed [DIFF_W-1:0]  n_diff;
    logic signed [ACC_W-1:0]   n_acc;
    logic signed [INTEG_W-1:0] n_integ;
    logic [SUM_W-1:0]          n_mag;
    logic [SUM_W-1:0]          n_shift;
    logic [CORR_W-1:0]         n_corr_mag;
    logic signed [DRIVE_W-1:0] n_corr;
    logic signed [DRIVE_W-1:0] n_base;
    logic signed [DRIVE_W-1:0] n_drive_l;
    logic signed [DRIVE_W-1:0] n_drive_r;

    // Register writes, always taken
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_speed <= BASE_SPEED_RST;
            r_gain_prop  <= GAIN_PROP_RST;
            r_gain_integ <= GAIN_INTEG_RST;
            r_gain_deriv <= GAIN_DERIV_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_BASE_SPEED: r_base_speed <= i_cfg.data[BASE_W-1:0];
                CFG_GAIN_PROP:  r_gain_prop  <= i_cfg.data[GAIN_W-1:0];
                CFG_GAIN_INTEG: r_gain_integ <= i_cfg.data[GAIN_W-1:0];
                CFG_GAIN_DERIV: r_gain_deriv <= i_cfg.data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Advance a stage when the next one is free or moving
    assign en_d       = !r_vd || o_out.ready;
    assign en_c       = !r_vc || en_d;
    assign en_b       = !r_vb || en_c;
    assign en_a       = !r_va || en_b;
    assign i_in.ready = en_a;
    assign accept     = i_in.valid && en_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
        end else begin
            if (en_a) r_va <= i_in.valid;
            if (en_b) r_vb <= r_va;
            if (en_c) r_vc <= r_vb;
            if (en_d) r_vd <= r_vc;
        end
    end

    // Error, difference and saturating integral
    always_comb begin
        n_err  = $signed({1'b0, i_in.sensor_left}) - $signed({1'b0, i_in.sensor_right});
        n_diff = DIFF_W'(n_err) - DIFF_W'(r_last_err);
        n_acc  = ACC_W'(r_integ_sum) + ACC_W'(n_err);
        priority if (n_acc > ACC_W'(INTEG_HI)) begin
            n_integ = INTEG_HI;
        end else if (n_acc < ACC_W'(INTEG_LO)) begin
            n_integ = INTEG_LO;
        end else begin
            n_integ = n_acc[INTEG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_err  <= '0;
            r_integ_sum <= '0;
        end else if (accept) begin
            r_last_err  <= n_err;
            r_integ_sum <= n_integ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_a) begin
            r_a_err   <= n_err;
            r_a_diff  <= n_diff;
            r_a_integ <= n_integ;
        end
    end

    // Gain products
    always_ff @(posedge i_clk) begin
        if (en_b) begin
            r_b_pp <= PP_W'($signed({1'b0, r_gain_prop}))  * PP_W'(r_a_err);
            r_b_pd <= PD_W'($signed({1'b0, r_gain_deriv})) * PD_W'(r_a_diff);
            r_b_pi <= PI_W'($signed({1'b0, r_gain_integ})) * PI_W'(r_a_integ);
        end
    end

    // Weighted sum
    always_ff @(posedge i_clk) begin
        if (en_c) begin
            r_c_sum <= SUM_W'(r_b_pp) + SUM_W'(r_b_pd) + SUM_W'(r_b_pi);
        end
    end

    // Correction: truncate magnitude toward zero, saturate, restore sign
    always_comb begin
        n_mag      = r_c_sum[SUM_W-1] ? SUM_W'(-r_c_sum) : SUM_W'(r_c_sum);
        n_shift    = n_mag >> GAIN_FRAC_BITS;
        n_corr_mag = (n_shift > SUM_W'(CORR_LIMIT)) ? CORR_LIMIT : n_shift[CORR_W-1:0];
        n_corr     = r_c_sum[SUM_W-1] ? -DRIVE_W'({1'b0, n_corr_mag})
                                      : DRIVE_W'({1'b0, n_corr_mag});
        n_base     = DRIVE_W'({1'b0, r_base_speed});
        n_drive_l  = n_base + n_corr;
        n_drive_r  = n_base - n_corr;
    end

    always_ff @(posedge i_clk) begin
        if (en_d) begin
            r_d_left  <= drive_to_duty(n_drive_l);
            r_d_right <= drive_to_duty(n_drive_r);
        end
    end

    // Result word
    assign o_out.valid      = r_vd;
    assign o_out.duty_left  = r_d_left.duty;
    assign o_out.duty_right = r_d_right.duty;
    assign o_out.spin_right = r_d_left.neg;
    assign o_out.spin_left  = r_d_right.neg;

endmodule

// ----- hw/rtl/lfps_checker.sv -----
// ---------------------------------------------------------------------------
// lfps_checker: port-level checks for the line-follower PID steering
// Watches the result channel for hand-off rules and steering consistency.
// ---------------------------------------------------------------------------
module lfps_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_duty_left,
    input logic [7:0] i_duty_right,
    input logic       i_spin_right,
    input logic       i_spin_left
);

    // Hold a stalled result word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_duty_left)
            && $stable(i_duty_right) && $stable(i_spin_right) && $stable(i_spin_left))
        else $error("result word changed while stalled");

    // Both drives cannot go negative with a non-negative base
    a_one_spin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_spin_left && i_spin_right))
        else $error("both spin flags raised");

    // A negative left drive implies the right drive is at least as strong
    a_spin_right_duty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_spin_right |-> i_duty_right >= i_duty_left)
        else $error("right duty below left duty on right spin");

    // No result straight out of reset
    a_reset_idle: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("result valid just after reset");

endmodule

bind line_follower_pid_steering lfps_checker u_lfps_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_duty_left  (o_out.duty_left),
    .i_duty_right (o_out.duty_right),
    .i_spin_right (o_out.spin_right),
    .i_spin_left  (o_out.spin_left)
);
